>>> rtl/core/swc_pkg.sv
// ----------------------------------------------------------------------------
// swc_pkg
// Shared types, request codes and the length load table for the
// square-wave channel core.
// ----------------------------------------------------------------------------
package swc_pkg;

   // request codes carried in req_type
   typedef enum logic [2:0] {
      REQ_TICK    = 3'd0,
      REQ_QUARTER = 3'd1,
      REQ_HALF    = 3'd2,
      REQ_REG_WR  = 3'd3,
      REQ_ENABLE  = 3'd4
   } req_code_type;

   // channel register indexes
   typedef enum logic [1:0] {
      REG_CTRL   = 2'd0,
      REG_SWEEP  = 2'd1,
      REG_PER_LO = 2'd2,
      REG_PER_HI = 2'd3
   } reg_index_type;

   localparam logic [11:0] LIMIT_FIRST  = 12'h7FE;
   localparam logic [11:0] LIMIT_SECOND = 12'h7FF;
   localparam logic [3:0]  DECAY_TOP    = 4'd15;
   localparam logic [10:0] MIN_PERIOD   = 11'd8;

   // one request as seen by the channel state
   typedef struct packed {
      logic [2:0] req_code;
      logic [1:0] reg_index;
      logic [7:0] write_data;
   } swc_item_type;

   // one result
   typedef struct packed {
      logic [3:0] amplitude;
      logic       length_active;
   } swc_result_type;

   // length counter load values
   localparam logic [7:0] LEN_TABLE [32] = '{
      8'd10,  8'd254, 8'd20, 8'd2,  8'd40, 8'd4,  8'd80, 8'd6,
      8'd160, 8'd8,   8'd60, 8'd10, 8'd14, 8'd12, 8'd26, 8'd14,
      8'd12,  8'd16,  8'd24, 8'd18, 8'd48, 8'd20, 8'd96, 8'd22,
      8'd192, 8'd24,  8'd72, 8'd26, 8'd16, 8'd28, 8'd32, 8'd30
   };

endpackage

>>> rtl/core/swc_state.sv
// ----------------------------------------------------------------------------
// swc_state
// Channel state registers (timer, sequencer, envelope, sweep, length) and
// the single-pass update for one request, with the result it produces.
// ----------------------------------------------------------------------------
module swc_state (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  swc_pkg::swc_item_type item,
   input  logic                  first_channel,
   output swc_pkg::swc_result_type result
);
   import swc_pkg::*;

   logic [10:0] period_reload_ff, period_reload_in;
   logic [10:0] period_count_ff,  period_count_in;
   logic [1:0]  duty_mode_ff,     duty_mode_in;
   logic [2:0]  step_index_ff,    step_index_in;
   logic        wave_bit_ff,      wave_bit_in;
   logic        chan_on_ff,       chan_on_in;
   logic        status_bit_ff,    status_bit_in;
   logic        muted_ff,         muted_in;
   logic [7:0]  len_count_ff,     len_count_in;
   logic [4:0]  len_index_ff,     len_index_in;
   logic        halt_loop_ff,     halt_loop_in;
   logic        env_start_ff,     env_start_in;
   logic        env_constant_ff,  env_constant_in;
   logic [3:0]  env_volume_ff,    env_volume_in;
   logic [3:0]  env_divider_ff,   env_divider_in;
   logic [3:0]  env_decay_ff,     env_decay_in;
   logic [3:0]  env_level_ff,     env_level_in;
   logic        sw_enable_ff,     sw_enable_in;
   logic [2:0]  sw_period_ff,     sw_period_in;
   logic        sw_negate_ff,     sw_negate_in;
   logic [2:0]  sw_shift_ff,      sw_shift_in;
   logic        sw_reload_ff,     sw_reload_in;
   logic [2:0]  sw_divider_ff,    sw_divider_in;
   logic [11:0] sw_target_ff,     sw_target_in;
   logic        sw_ok_ff,         sw_ok_in;

   // sweep target arithmetic
   logic [10:0] sw_delta;
   logic [11:0] sw_sum;
   logic [11:0] sw_diff;
   logic [11:0] sw_calc;
   logic [11:0] sw_limit;
   logic [3:0]  decay_stepped;

   always_comb begin
      sw_delta = period_reload_ff >> sw_shift_ff;
      sw_sum   = {1'b0, period_reload_ff} + {1'b0, sw_delta};
      sw_diff  = {1'b0, period_reload_ff} - {1'b0, sw_delta} - {11'd0, first_channel};
      sw_limit = first_channel ? LIMIT_FIRST : LIMIT_SECOND;
      if (sw_enable_ff && (sw_shift_ff != 3'd0)) begin
         sw_calc = sw_negate_ff ? sw_diff : sw_sum;
      end else begin
         sw_calc = sw_target_ff;
      end
   end

   // next state for one request
   always_comb begin
      period_reload_in = period_reload_ff;
      period_count_in  = period_count_ff;
      duty_mode_in     = duty_mode_ff;
      step_index_in    = step_index_ff;
      wave_bit_in      = wave_bit_ff;
      chan_on_in       = chan_on_ff;
      status_bit_in    = status_bit_ff;
      muted_in         = muted_ff;
      len_count_in     = len_count_ff;
      len_index_in     = len_index_ff;
      halt_loop_in     = halt_loop_ff;
      env_start_in     = env_start_ff;
      env_constant_in  = env_constant_ff;
      env_volume_in    = env_volume_ff;
      env_divider_in   = env_divider_ff;
      env_decay_in     = env_decay_ff;
      env_level_in     = env_level_ff;
      sw_enable_in     = sw_enable_ff;
      sw_period_in     = sw_period_ff;
      sw_negate_in     = sw_negate_ff;
      sw_shift_in      = sw_shift_ff;
      sw_reload_in     = sw_reload_ff;
      sw_divider_in    = sw_divider_ff;
      sw_target_in     = sw_target_ff;
      sw_ok_in         = sw_ok_ff;
      decay_stepped    = env_decay_ff;

      case (item.req_code)
         REQ_TICK: begin
            if (chan_on_ff) begin
               if (period_count_ff == 11'd0) begin
                  period_count_in = period_reload_ff;
                  case (duty_mode_ff)
                     2'd0:    wave_bit_in = (step_index_ff >= 3'd7);
                     2'd1:    wave_bit_in = (step_index_ff >= 3'd6);
                     2'd2:    wave_bit_in = (step_index_ff >= 3'd4);
                     default: wave_bit_in = (step_index_ff < 3'd6);
                  endcase
                  step_index_in = step_index_ff - 3'd1;
               end else begin
                  period_count_in = period_count_ff - 11'd1;
               end
               muted_in = !(sw_ok_ff && (len_count_ff != 8'd0));
            end
         end
         REQ_QUARTER: begin
            if (env_start_ff) begin
               env_start_in   = 1'b0;
               decay_stepped  = DECAY_TOP;
               env_divider_in = env_volume_ff;
            end else if (env_divider_ff == 4'd0) begin
               env_divider_in = env_volume_ff;
               if (env_decay_ff != 4'd0) begin
                  decay_stepped = env_decay_ff - 4'd1;
               end else if (halt_loop_ff) begin
                  decay_stepped = DECAY_TOP;
               end
            end else begin
               env_divider_in = env_divider_ff - 4'd1;
            end
            env_decay_in = decay_stepped;
            env_level_in = env_constant_ff ? env_volume_ff : decay_stepped;
         end
         REQ_HALF: begin
            // sweep: target, mute check, period update, divider
            if ((sw_calc > sw_limit) || (period_reload_ff < MIN_PERIOD)) begin
               sw_target_in = 12'd0;
               sw_ok_in     = 1'b0;
            end else begin
               sw_target_in = sw_calc;
               sw_ok_in     = 1'b1;
            end
            if ((sw_divider_ff == 3'd0) && sw_enable_ff && (sw_shift_ff != 3'd0) && sw_ok_in)
            begin
               period_reload_in = sw_target_in[10:0];
            end
            if ((sw_divider_ff == 3'd0) || sw_reload_ff) begin
               sw_reload_in  = 1'b0;
               sw_divider_in = sw_period_ff;
            end else if (sw_enable_ff) begin
               sw_divider_in = sw_divider_ff - 3'd1;
            end
            // length counter
            if (!chan_on_ff) begin
               len_count_in = 8'd0;
            end else if ((len_count_ff != 8'd0) && !halt_loop_ff) begin
               len_count_in = len_count_ff - 8'd1;
            end
         end
         REQ_REG_WR: begin
            unique case (item.reg_index)
               REG_CTRL: begin
                  duty_mode_in    = item.write_data[7:6];
                  halt_loop_in    = item.write_data[5];
                  env_constant_in = item.write_data[4];
                  env_volume_in   = item.write_data[3:0];
               end
               REG_SWEEP: begin
                  sw_enable_in = item.write_data[7];
                  sw_period_in = item.write_data[6:4];
                  sw_negate_in = item.write_data[3];
                  sw_shift_in  = item.write_data[2:0];
                  sw_reload_in = 1'b1;
               end
               REG_PER_LO: begin
                  period_reload_in = {period_reload_ff[10:8], item.write_data};
               end
               default: begin
                  period_reload_in = {item.write_data[2:0], period_reload_ff[7:0]};
                  len_index_in     = item.write_data[7:3];
                  step_index_in    = 3'd0;
                  period_count_in  = 11'd0;
                  env_start_in     = 1'b1;
                  if (status_bit_ff) begin
                     chan_on_in = 1'b1;
                  end
               end
            endcase
         end
         REQ_ENABLE: begin
            status_bit_in = item.write_data[0];
            chan_on_in    = item.write_data[0];
            len_count_in  = item.write_data[0] ? LEN_TABLE[len_index_ff] : 8'd0;
         end
         default: begin
         end
      endcase
   end

   // result from the updated state
   always_comb begin
      result.amplitude     = (wave_bit_in && !muted_in) ? env_level_in : 4'd0;
      result.length_active = chan_on_in && (len_count_in != 8'd0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         period_reload_ff <= '0;
         period_count_ff  <= '0;
         duty_mode_ff     <= '0;
         step_index_ff    <= '0;
         wave_bit_ff      <= 1'b0;
         chan_on_ff       <= 1'b0;
         status_bit_ff    <= 1'b0;
         muted_ff         <= 1'b0;
         len_count_ff     <= '0;
         len_index_ff     <= '0;
         halt_loop_ff     <= 1'b0;
         env_start_ff     <= 1'b0;
         env_constant_ff  <= 1'b0;
         env_volume_ff    <= '0;
         env_divider_ff   <= '0;
         env_decay_ff     <= '0;
         env_level_ff     <= '0;
         sw_enable_ff     <= 1'b0;
         sw_period_ff     <= '0;
         sw_negate_ff     <= 1'b0;
         sw_shift_ff      <= '0;
         sw_reload_ff     <= 1'b0;
         sw_divider_ff    <= '0;
         sw_target_ff     <= '0;
         sw_ok_ff         <= 1'b0;
      end else if (fire) begin
         period_reload_ff <= period_reload_in;
         period_count_ff  <= period_count_in;
         duty_mode_ff     <= duty_mode_in;
         step_index_ff    <= step_index_in;
         wave_bit_ff      <= wave_bit_in;
         chan_on_ff       <= chan_on_in;
         status_bit_ff    <= status_bit_in;
         muted_ff         <= muted_in;
         len_count_ff     <= len_count_in;
         len_index_ff     <= len_index_in;
         halt_loop_ff     <= halt_loop_in;
         env_start_ff     <= env_start_in;
         env_constant_ff  <= env_constant_in;
         env_volume_ff    <= env_volume_in;
         env_divider_ff   <= env_divider_in;
         env_decay_ff     <= env_decay_in;
         env_level_ff     <= env_level_in;
         sw_enable_ff     <= sw_enable_in;
         sw_period_ff     <= sw_period_in;
         sw_negate_ff     <= sw_negate_in;
         sw_shift_ff      <= sw_shift_in;
         sw_reload_ff     <= sw_reload_in;
         sw_divider_ff    <= sw_divider_in;
         sw_target_ff     <= sw_target_in;
         sw_ok_ff         <= sw_ok_in;
      end
   end

`ifndef SYNTHESIS
   // disabling the channel clears status and length
   assert property (@(posedge clock) disable iff (reset)
      (fire && (item.req_code == REQ_ENABLE) && !item.write_data[0])
      |=> (!status_bit_ff && !chan_on_ff && (len_count_ff == 8'd0)))
      else $error("disable write did not clear the length counter");

   // a tick on a stopped channel leaves timer and mute alone
   assert property (@(posedge clock) disable iff (reset)
      (fire && (item.req_code == REQ_TICK) && !chan_on_ff)
      |=> ($stable(period_count_ff) && $stable(muted_ff) && $stable(step_index_ff)))
      else $error("timer moved on a stopped channel");

   // envelope level moves only on a quarter frame
   assert property (@(posedge clock) disable iff (reset)
      !(fire && (item.req_code == REQ_QUARTER)) |=> $stable(env_level_ff))
      else $error("envelope level changed outside a quarter frame");
`endif

endmodule

>>> rtl/core/square_wave_channel_core.sv
// ----------------------------------------------------------------------------
// square_wave_channel_core
// One square-wave sound channel: request register, single-pass channel
// update and a result register, plus the channel-select control register.
// ----------------------------------------------------------------------------
//   channel   direction  handshake          payload
//   req_      in         valid / ready      req_type, req_reg_index, req_write_data
//   rsp_      out        valid / ready      rsp_amplitude, rsp_length_active
//   csr_      in         write enable only  csr_wr_data (first channel select)
//
// Each request passes from acceptance into the request register, then
// through the channel update into the result register. One request per
// cycle is sustained while the result is not stalled; the channel update is
// the only logic stage and the state registers feed it back in the next cycle.
// A stalled result holds the result register, the request register then
// fills and req_ready drops.
// Reset clears the channel state and sets first channel select.
// ----------------------------------------------------------------------------
module square_wave_channel_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_type,
   input  logic [1:0] req_reg_index,
   input  logic [7:0] req_write_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_amplitude,
   output logic       rsp_length_active,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import swc_pkg::*;

   logic           first_channel_ff;
   logic           in_valid_ff;
   swc_item_type   in_item_ff;
   logic           rsp_valid_ff;
   swc_result_type rsp_result_ff;
   swc_result_type result_in;
   logic           advance;
   logic           req_accept;

   // request moves into the result register when that register is empty or being read out
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   // channel select register
   always_ff @(posedge clock) begin
      if (reset) begin
         first_channel_ff <= 1'b1;
      end else if (csr_wr_en) begin
         first_channel_ff <= csr_wr_data;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff.req_code   <= req_type;
         in_item_ff.reg_index  <= req_reg_index;
         in_item_ff.write_data <= req_write_data;
      end
   end

   // channel state and update
   swc_state u_state (
      .clock         (clock),
      .reset         (reset),
      .fire          (advance),
      .item          (in_item_ff),
      .first_channel (first_channel_ff),
      .result        (result_in)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_result_ff <= result_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_amplitude     = rsp_result_ff.amplitude;
   assign rsp_length_active = rsp_result_ff.length_active;

`ifndef SYNTHESIS
   // an accepted request is held in the request register
   assert property (@(posedge clock) disable iff (reset)
      req_accept |=> in_valid_ff)
      else $error("accepted request lost");

   // every update produces a pending result
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("update without a result");

   // a blocked request keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_item_ff)))
      else $error("blocked request changed");
`endif

endmodule
